/* rtl/segment_segment_intersect_2d_defines.svh */
// assertion macros shared by the segment intersection rtl
`ifndef SEGMENT_SEGMENT_INTERSECT_2D_DEFINES_SVH
`define SEGMENT_SEGMENT_INTERSECT_2D_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SSI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssi check failed");
`define SSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssi check failed");
`else
`define SSI_ASSERT_IMPL(lbl, ante, cons)
`define SSI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/ssi_pkg.sv */
// shared types and constants of the segment intersection block
`timescale 1ns / 1ps
package ssi_pkg;

  // field widths
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int REL_W     = 35;
  localparam int PROD_W    = 66;
  localparam int DIV_W     = 68;
  localparam int WIDE_W    = 105;
  localparam int PARAM_W   = 17;
  localparam int CEPS_W    = 31;
  localparam int KEPS_W    = 16;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLLINEAR_EPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COORD_EPS     = 1'b1;

  // flags that travel with an item through the divider
  typedef struct packed {
    logic hit;
    logic sat;
  } ssi_tag_t;

endpackage

/* rtl/ssi_div.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module ssi_div #(
  parameter int N = 16,
  parameter int W = 68
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [W-1:0]     in_rem,
  input  logic [W-1:0]     in_den,
  input  ssi_pkg::ssi_tag_t in_tag,
  output logic             out_v,
  output logic [N-1:0]     out_q,
  output ssi_pkg::ssi_tag_t out_tag
);
  import ssi_pkg::*;

  logic           v_r   [N];
  logic [W-1:0]   rem_r [N];
  logic [W-1:0]   den_r [N];
  logic [N-1:0]   q_r   [N];
  ssi_tag_t       tag_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic           prv_v;
    logic [W-1:0]   prv_rem;
    logic [W-1:0]   prv_den;
    logic [N-1:0]   prv_q;
    ssi_tag_t       prv_tag;
    logic [W:0]     shf;
    logic           ge;
    logic [W-1:0]   rem_nxt;

    if (k == 0) begin : g_first
      assign prv_v   = in_v;
      assign prv_rem = in_rem;
      assign prv_den = in_den;
      assign prv_q   = '0;
      assign prv_tag = in_tag;
    end else begin : g_next
      assign prv_v   = v_r[k-1];
      assign prv_rem = rem_r[k-1];
      assign prv_den = den_r[k-1];
      assign prv_q   = q_r[k-1];
      assign prv_tag = tag_r[k-1];
    end

    // shift in one bit, subtract when it fits
    assign shf     = {prv_rem, 1'b0};
    assign ge      = shf >= {1'b0, prv_den};
    assign rem_nxt = ge ? W'(shf - {1'b0, prv_den}) : shf[W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= prv_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= prv_den;
        q_r[k]   <= {prv_q[N-2:0], ge};
        tag_r[k] <= prv_tag;
      end
    end
  end

  assign out_v   = v_r[N-1];
  assign out_q   = q_r[N-1];
  assign out_tag = tag_r[N-1];

endmodule

/* rtl/segment_segment_intersect_2d.sv */
// top level of the 2d segment intersection test
`timescale 1ns / 1ps
// Takes one segment pair per cycle while in_tready is high and returns one item per
// pair: hit and the distance ratio along the first segment. The path from input to
// output runs through seven arithmetic stages (differences, cross products,
// denominator and numerator, sign fix, split wide products, sums, box compares),
// then the divider, which produces one quotient bit per stage, then the output
// register. A skid register behind the output holds one item and lets the input
// keep flowing while the output is stalled; in_tready falls only once it is full.
`include "segment_segment_intersect_2d_defines.svh"
module segment_segment_intersect_2d #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // config write port
  input  logic                          cfg_we,
  input  logic [ssi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssi_pkg::CEPS_W-1:0]    cfg_wdata,
  // in_tdata from bit 0: first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,
  // out_tdata from bit 0: param_along_first, zero padding
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,
  // out_tuser: hit
  output logic         out_tuser
);
  import ssi_pkg::*;

  localparam int QW = PARAM_FRAC_BITS + 1;

  logic [CEPS_W-1:0] col_eps_r;
  logic [KEPS_W-1:0] crd_eps_r;
  logic en;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_eps_r <= CEPS_W'(7);
      crd_eps_r <= KEPS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLLINEAR_EPS: col_eps_r <= cfg_wdata;
        CFG_COORD_EPS:     crd_eps_r <= cfg_wdata[KEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: box overlap, differences, relative box edges
  logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic signed [COORD_W-1:0] lox, hix, loy, hiy;
  assign ax = in_tdata[31:0];
  assign ay = in_tdata[63:32];
  assign bx = in_tdata[95:64];
  assign by = in_tdata[127:96];
  assign cx = in_tdata[159:128];
  assign cy = in_tdata[191:160];
  assign dx = in_tdata[223:192];
  assign dy = in_tdata[255:224];

  always_comb begin
    logic signed [COORD_W-1:0] m1, m2;
    m1  = (ax < bx) ? ax : bx;
    m2  = (cx < dx) ? cx : dx;
    lox = (m1 > m2) ? m1 : m2;
    m1  = (ax > bx) ? ax : bx;
    m2  = (cx > dx) ? cx : dx;
    hix = (m1 < m2) ? m1 : m2;
    m1  = (ay < by) ? ay : by;
    m2  = (cy < dy) ? cy : dy;
    loy = (m1 > m2) ? m1 : m2;
    m1  = (ay > by) ? ay : by;
    m2  = (cy > dy) ? cy : dy;
    hiy = (m1 < m2) ? m1 : m2;
  end

  logic s1_v_r, s1_box_r;
  logic signed [DIFF_W-1:0] s1_v1x_r, s1_v1y_r, s1_v2x_r, s1_v2y_r, s1_wx_r, s1_wy_r;
  logic signed [REL_W-1:0]  s1_lx_r, s1_hx_r, s1_ly_r, s1_hy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_box_r <= (lox <= hix) && (loy <= hiy);
      s1_v1x_r <= DIFF_W'(bx) - DIFF_W'(ax);
      s1_v1y_r <= DIFF_W'(by) - DIFF_W'(ay);
      s1_v2x_r <= DIFF_W'(dx) - DIFF_W'(cx);
      s1_v2y_r <= DIFF_W'(dy) - DIFF_W'(cy);
      s1_wx_r  <= DIFF_W'(cx) - DIFF_W'(ax);
      s1_wy_r  <= DIFF_W'(cy) - DIFF_W'(ay);
      s1_lx_r  <= REL_W'(lox) - REL_W'(crd_eps_r) - REL_W'(ax);
      s1_hx_r  <= REL_W'(hix) + REL_W'(crd_eps_r) - REL_W'(ax);
      s1_ly_r  <= REL_W'(loy) - REL_W'(crd_eps_r) - REL_W'(ay);
      s1_hy_r  <= REL_W'(hiy) + REL_W'(crd_eps_r) - REL_W'(ay);
    end
  end

  // stage 2: cross products
  logic s2_v_r, s2_box_r;
  logic signed [PROD_W-1:0] s2_p0_r, s2_p1_r, s2_p2_r, s2_p3_r;
  logic signed [DIFF_W-1:0] s2_v1x_r, s2_v1y_r;
  logic signed [REL_W-1:0]  s2_lx_r, s2_hx_r, s2_ly_r, s2_hy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_box_r <= s1_box_r;
      s2_p0_r  <= s1_v1x_r * s1_v2y_r;
      s2_p1_r  <= s1_v1y_r * s1_v2x_r;
      s2_p2_r  <= s1_wx_r * s1_v2y_r;
      s2_p3_r  <= s1_wy_r * s1_v2x_r;
      s2_v1x_r <= s1_v1x_r;
      s2_v1y_r <= s1_v1y_r;
      s2_lx_r  <= s1_lx_r;
      s2_hx_r  <= s1_hx_r;
      s2_ly_r  <= s1_ly_r;
      s2_hy_r  <= s1_hy_r;
    end
  end

  // stage 3: denominator and numerator
  logic s3_v_r, s3_box_r;
  logic signed [DIV_W-1:0]  s3_den_r, s3_num_r;
  logic signed [DIFF_W-1:0] s3_v1x_r, s3_v1y_r;
  logic signed [REL_W-1:0]  s3_lx_r, s3_hx_r, s3_ly_r, s3_hy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_box_r <= s2_box_r;
      s3_den_r <= DIV_W'(s2_p0_r) - DIV_W'(s2_p1_r);
      s3_num_r <= DIV_W'(s2_p2_r) - DIV_W'(s2_p3_r);
      s3_v1x_r <= s2_v1x_r;
      s3_v1y_r <= s2_v1y_r;
      s3_lx_r  <= s2_lx_r;
      s3_hx_r  <= s2_hx_r;
      s3_ly_r  <= s2_ly_r;
      s3_hy_r  <= s2_hy_r;
    end
  end

  // stage 4: make the denominator positive
  logic s4_v_r, s4_box_r, s4_nz_r;
  logic signed [DIV_W-1:0]  s4_den_r, s4_num_r;
  logic signed [DIFF_W-1:0] s4_v1x_r, s4_v1y_r;
  logic signed [REL_W-1:0]  s4_lx_r, s4_hx_r, s4_ly_r, s4_hy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_box_r <= s3_box_r;
      s4_nz_r  <= s3_den_r != '0;
      s4_den_r <= s3_den_r[DIV_W-1] ? -s3_den_r : s3_den_r;
      s4_num_r <= s3_den_r[DIV_W-1] ? -s3_num_r : s3_num_r;
      s4_v1x_r <= s3_v1x_r;
      s4_v1y_r <= s3_v1y_r;
      s4_lx_r  <= s3_lx_r;
      s4_hx_r  <= s3_hx_r;
      s4_ly_r  <= s3_ly_r;
      s4_hy_r  <= s3_hy_r;
    end
  end

  // stage 5: threshold, magnitude, split partial products
  logic [DIV_W-1:0] thr;
  logic signed [34:0] num_lo, den_lo;
  logic signed [33:0] num_hi, den_hi;
  assign thr    = DIV_W'(col_eps_r) << COORD_FRAC_BITS;
  assign num_lo = $signed({1'b0, s4_num_r[33:0]});
  assign num_hi = $signed(s4_num_r[67:34]);
  assign den_lo = $signed({1'b0, s4_den_r[33:0]});
  assign den_hi = $signed(s4_den_r[67:34]);

  logic s5_v_r, s5_box_r, s5_dok_r;
  logic [DIV_W-1:0] s5_den_r, s5_abs_r;
  logic signed [69:0] s5_mxl_r, s5_myl_r, s5_lxl_r, s5_hxl_r, s5_lyl_r, s5_hyl_r;
  logic signed [69:0] s5_mxh_r, s5_myh_r, s5_lxh_r, s5_hxh_r, s5_lyh_r, s5_hyh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_box_r <= s4_box_r;
      s5_dok_r <= s4_nz_r && (DIV_W'(s4_den_r) >= thr);
      s5_den_r <= s4_den_r;
      s5_abs_r <= s4_num_r[DIV_W-1] ? DIV_W'(-s4_num_r) : DIV_W'(s4_num_r);
      s5_mxl_r <= num_lo * s4_v1x_r;
      s5_mxh_r <= num_hi * s4_v1x_r;
      s5_myl_r <= num_lo * s4_v1y_r;
      s5_myh_r <= num_hi * s4_v1y_r;
      s5_lxl_r <= s4_lx_r * den_lo;
      s5_lxh_r <= s4_lx_r * den_hi;
      s5_hxl_r <= s4_hx_r * den_lo;
      s5_hxh_r <= s4_hx_r * den_hi;
      s5_lyl_r <= s4_ly_r * den_lo;
      s5_lyh_r <= s4_ly_r * den_hi;
      s5_hyl_r <= s4_hy_r * den_lo;
      s5_hyh_r <= s4_hy_r * den_hi;
    end
  end

  // stage 6: join partial products
  logic s6_v_r, s6_box_r, s6_dok_r;
  logic [DIV_W-1:0] s6_den_r, s6_abs_r;
  logic signed [WIDE_W-1:0] s6_mx_r, s6_my_r, s6_lx_r, s6_hx_r, s6_ly_r, s6_hy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_box_r <= s5_box_r;
      s6_dok_r <= s5_dok_r;
      s6_den_r <= s5_den_r;
      s6_abs_r <= s5_abs_r;
      s6_mx_r  <= (WIDE_W'(s5_mxh_r) <<< 34) + WIDE_W'(s5_mxl_r);
      s6_my_r  <= (WIDE_W'(s5_myh_r) <<< 34) + WIDE_W'(s5_myl_r);
      s6_lx_r  <= (WIDE_W'(s5_lxh_r) <<< 34) + WIDE_W'(s5_lxl_r);
      s6_hx_r  <= (WIDE_W'(s5_hxh_r) <<< 34) + WIDE_W'(s5_hxl_r);
      s6_ly_r  <= (WIDE_W'(s5_lyh_r) <<< 34) + WIDE_W'(s5_lyl_r);
      s6_hy_r  <= (WIDE_W'(s5_hyh_r) <<< 34) + WIDE_W'(s5_hyl_r);
    end
  end

  // stage 7: point inside widened box, saturation check
  logic s7_v_r;
  logic [DIV_W-1:0] s7_den_r, s7_abs_r;
  ssi_tag_t s7_tag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_tag_r.hit <= s6_box_r && s6_dok_r
                   && (s6_mx_r >= s6_lx_r) && (s6_mx_r <= s6_hx_r)
                   && (s6_my_r >= s6_ly_r) && (s6_my_r <= s6_hy_r);
      s7_tag_r.sat <= s6_abs_r >= s6_den_r;
      s7_den_r     <= s6_den_r;
      s7_abs_r     <= s6_abs_r;
    end
  end

  // valid bits of the arithmetic stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  // ratio divider
  logic                   dv_v;
  logic [PARAM_FRAC_BITS-1:0] dv_q;
  ssi_tag_t               dv_tag;

  ssi_div #(
    .N(PARAM_FRAC_BITS),
    .W(DIV_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (s7_v_r),
    .in_rem (s7_abs_r),
    .in_den (s7_den_r),
    .in_tag (s7_tag_r),
    .out_v  (dv_v),
    .out_q  (dv_q),
    .out_tag(dv_tag)
  );

  // final ratio, saturated and masked to the field
  logic [QW-1:0]         fin;
  logic [QW+PARAM_W-1:0] fin_ext;
  logic [PARAM_W-1:0]    p_param;
  assign fin     = !dv_tag.hit ? '0 :
                   dv_tag.sat  ? (QW'(1) << PARAM_FRAC_BITS) : QW'(dv_q);
  assign fin_ext = {{PARAM_W{1'b0}}, fin};
  assign p_param = fin_ext[PARAM_W-1:0];

  // output register with skid
  logic out_v_r, out_hit_r, skid_v_r, skid_hit_r;
  logic [PARAM_W-1:0] out_param_r, skid_param_r;
  logic take;

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign take      = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || take) begin
      out_v_r <= dv_v;
    end else if (dv_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_hit_r   <= skid_hit_r;
        out_param_r <= skid_param_r;
      end
    end else if (!out_v_r || take) begin
      out_hit_r   <= dv_tag.hit;
      out_param_r <= p_param;
    end else begin
      skid_hit_r   <= dv_tag.hit;
      skid_param_r <= p_param;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {7'b0, out_param_r};

  // checks
  `SSI_ASSERT_IMPL(a_skid_has_out, skid_v_r, out_v_r)
  `SSI_ASSERT_IMPL(a_miss_zero, out_v_r && !out_hit_r, out_param_r == '0)
  `SSI_ASSERT_NEXT(a_skid_holds, skid_v_r && !out_tready, skid_v_r && !in_tready)

endmodule
